FILE: src/fraction_reduce_binary_gcd_top_macros.svh
// ----------------------------------------------------------------------------
// fraction_reduce_binary_gcd_top_macros.svh
// Assertion macros used by the checker file of the fraction reducer.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_BINARY_GCD_TOP_MACROS_SVH
`define FRACTION_REDUCE_BINARY_GCD_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FRGCD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frgcd assertion failed");

// Next-cycle implication, disabled during reset.
`define FRGCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frgcd assertion failed");

`endif

FILE: src/frgcd_pkg.sv
// ----------------------------------------------------------------------------
// frgcd_pkg
// Widths, types, state encoding and width helpers of the fraction reducer.
// ----------------------------------------------------------------------------
package frgcd_pkg;

   // Datapath width and fixed port field width
   localparam int VALUE_WIDTH = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int TWOS_WIDTH  = $clog2(VALUE_WIDTH + 1);
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [FIELD_WIDTH-1:0] field_type;
   typedef logic [TWOS_WIDTH-1:0]  twos_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_RESTORE,
      ST_NUM_GO,
      ST_NUM_WAIT,
      ST_DEN_GO,
      ST_DEN_WAIT,
      ST_OUT
   } state_type;

   // Field to datapath width: truncate or zero-extend
   function automatic value_type to_value(input field_type f);
      logic [VALUE_WIDTH+FIELD_WIDTH-1:0] wide;
      wide = {{VALUE_WIDTH{1'b0}}, f};
      return wide[VALUE_WIDTH-1:0];
   endfunction

   // Datapath to field width: truncate or zero-extend
   function automatic field_type to_field(input value_type v);
      logic [VALUE_WIDTH+FIELD_WIDTH-1:0] wide;
      wide = {{FIELD_WIDTH{1'b0}}, v};
      return wide[FIELD_WIDTH-1:0];
   endfunction

endpackage

FILE: src/frgcd_divider.sv
// ----------------------------------------------------------------------------
// frgcd_divider
// Serial restoring divider: one quotient bit per cycle, VALUE_WIDTH quotient bits.
// ----------------------------------------------------------------------------
module frgcd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  frgcd_pkg::value_type dividend,
   input  frgcd_pkg::value_type divisor,
   output logic                 done,
   output frgcd_pkg::value_type quotient
);
   import frgcd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   count_type            count_ff, count_in;
   value_type            q_ff, q_in;
   value_type            rem_ff, rem_in;
   value_type            dvs_ff, dvs_in;
   logic [VALUE_WIDTH:0] shifted;
   logic [VALUE_WIDTH:0] trial;

   // One restoring step
   assign shifted = {rem_ff, q_ff[VALUE_WIDTH-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (busy_ff) begin
         if (!trial[VALUE_WIDTH]) begin
            rem_in = trial[VALUE_WIDTH-1:0];
            q_in   = {q_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[VALUE_WIDTH-1:0];
            q_in   = {q_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - count_type'(1);
         if (count_ff == count_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         count_in = count_type'(VALUE_WIDTH);
         q_in     = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: src/fraction_reduce_binary_gcd_top.sv
// ----------------------------------------------------------------------------
// fraction_reduce_binary_gcd_top
// Reduces an unsigned fraction by its greatest common divisor (binary GCD).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_* carries numerator and denominator; result channel
//   rsp_* returns the reduced pair, the divisor and a zero-denominator flag.
//   Both channels are valid/ready; one result item per input item.
//   The block takes one item at a time: req_ready is high only when idle.
//   A zero denominator skips the GCD loop and the divider and goes straight
//   to the output. Otherwise the binary GCD loop takes one shift or
//   halved-difference step per cycle, the shared factors of two are then
//   restored one at a time, and the serial divider computes the two
//   quotients one after the other.
//   Results wait in an output register; while rsp_ready is low the finished
//   item holds there and the sequencer waits before loading the next one.
//   Synchronous reset returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module fraction_reduce_binary_gcd_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  frgcd_pkg::field_type req_numerator,
   input  frgcd_pkg::field_type req_denominator,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output frgcd_pkg::field_type rsp_reduced_numerator,
   output frgcd_pkg::field_type rsp_reduced_denominator,
   output frgcd_pkg::field_type rsp_common_divisor,
   output logic                 rsp_zero_denominator_error
);
   import frgcd_pkg::*;

   state_type            state_ff, state_in;
   value_type            num_ff, num_in;
   value_type            den_ff, den_in;
   value_type            u_ff, u_in;
   value_type            v_ff, v_in;
   value_type            g_ff, g_in;
   twos_type             twos_ff, twos_in;
   value_type            res_num_ff, res_num_in;
   value_type            res_den_ff, res_den_in;
   logic                 res_err_ff, res_err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   field_type            out_num_ff, out_num_in;
   field_type            out_den_ff, out_den_in;
   field_type            out_g_ff, out_g_in;
   logic                 out_err_ff, out_err_in;
   logic [VALUE_WIDTH:0] diff_uv;
   logic [VALUE_WIDTH:0] diff_vu;
   value_type            req_num;
   value_type            req_den;
   logic                 div_start;
   logic                 div_done;
   value_type            div_dividend;
   value_type            div_quotient;

   assign req_num = to_value(req_numerator);
   assign req_den = to_value(req_denominator);

   // Difference units (u-v and v-u) for the odd/odd GCD step
   assign diff_uv = {1'b0, u_ff} - {1'b0, v_ff};
   assign diff_vu = {1'b0, v_ff} - {1'b0, u_ff};

   // Serial divider, run once per quotient
   assign div_dividend = (state_ff == ST_NUM_GO) ? num_ff : den_ff;

   frgcd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      g_in         = g_ff;
      twos_in      = twos_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_g_in     = out_g_ff;
      out_err_in   = out_err_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in  = req_num;
               den_in  = req_den;
               u_in    = req_num;
               v_in    = req_den;
               twos_in = '0;
               if (req_den == '0) begin
                  // zero denominator: pass through and flag
                  res_num_in = req_num;
                  res_den_in = '0;
                  g_in       = '0;
                  res_err_in = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  res_err_in = 1'b0;
                  state_in   = ST_GCD;
               end
            end
         end

         ST_GCD: begin
            priority if (u_ff == v_ff) begin
               g_in     = u_ff;
               state_in = ST_RESTORE;
            end else if (u_ff == '0) begin
               g_in     = v_ff;
               state_in = ST_RESTORE;
            end else if (v_ff == '0) begin
               g_in     = u_ff;
               state_in = ST_RESTORE;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in    = u_ff >> 1;
               v_in    = v_ff >> 1;
               twos_in = twos_ff + twos_type'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!diff_uv[VALUE_WIDTH]) begin
               u_in = diff_uv[VALUE_WIDTH:1];
            end else begin
               u_in = diff_vu[VALUE_WIDTH:1];
               v_in = u_ff;
            end
         end

         // put back the shared factors of two, one per cycle
         ST_RESTORE: begin
            if (twos_ff == '0) begin
               state_in = ST_NUM_GO;
            end else begin
               g_in    = g_ff << 1;
               twos_in = twos_ff - twos_type'(1);
            end
         end

         ST_NUM_GO: begin
            div_start = 1'b1;
            state_in  = ST_NUM_WAIT;
         end

         ST_NUM_WAIT: begin
            if (div_done) begin
               res_num_in = div_quotient;
               state_in   = ST_DEN_GO;
            end
         end

         ST_DEN_GO: begin
            div_start = 1'b1;
            state_in  = ST_DEN_WAIT;
         end

         ST_DEN_WAIT: begin
            if (div_done) begin
               res_den_in = div_quotient;
               state_in   = ST_OUT;
            end
         end

         // hand the item to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_num_in   = to_field(res_num_ff);
               out_den_in   = to_field(res_den_ff);
               out_g_in     = to_field(g_ff);
               out_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff     <= num_in;
      den_ff     <= den_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      g_ff       <= g_in;
      twos_ff    <= twos_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_err_ff <= res_err_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_g_ff   <= out_g_in;
      out_err_ff <= out_err_in;
   end

   assign req_ready                  = (state_ff == ST_IDLE);
   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_reduced_numerator      = out_num_ff;
   assign rsp_reduced_denominator    = out_den_ff;
   assign rsp_common_divisor         = out_g_ff;
   assign rsp_zero_denominator_error = out_err_ff;

endmodule

FILE: src/frgcd_checker.sv
// ----------------------------------------------------------------------------
// frgcd_checker
// Port-level checks of the fraction reducer, bound to the top level.
// ----------------------------------------------------------------------------
`include "fraction_reduce_binary_gcd_top_macros.svh"

module frgcd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input frgcd_pkg::field_type rsp_reduced_numerator,
   input frgcd_pkg::field_type rsp_reduced_denominator,
   input frgcd_pkg::field_type rsp_common_divisor,
   input logic                 rsp_zero_denominator_error
);
   import frgcd_pkg::*;

   // a stalled result item holds
   `FRGCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reduced_numerator) && $stable(rsp_reduced_denominator) && $stable(rsp_common_divisor) && $stable(rsp_zero_denominator_error))

   // the block is busy right after taking an item
   `FRGCD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // zero denominator reports a zero divisor and zero denominator
   `FRGCD_ASSERT_SAME(a_err_fields, rsp_valid && rsp_zero_denominator_error, rsp_common_divisor == '0 && rsp_reduced_denominator == '0)

   // a valid fraction always has a nonzero divisor
   `FRGCD_ASSERT_SAME(a_gcd_nonzero, rsp_valid && !rsp_zero_denominator_error, rsp_common_divisor != '0)

   // zero numerator reduces to 0/1
   `FRGCD_ASSERT_SAME(a_zero_num, rsp_valid && !rsp_zero_denominator_error && rsp_reduced_numerator == '0, rsp_reduced_denominator == field_type'(1))

endmodule

bind fraction_reduce_binary_gcd_top frgcd_checker u_frgcd_checker (
   .clock                      (clock),
   .reset                      (reset),
   .req_valid                  (req_valid),
   .req_ready                  (req_ready),
   .rsp_valid                  (rsp_valid),
   .rsp_ready                  (rsp_ready),
   .rsp_reduced_numerator      (rsp_reduced_numerator),
   .rsp_reduced_denominator    (rsp_reduced_denominator),
   .rsp_common_divisor         (rsp_common_divisor),
   .rsp_zero_denominator_error (rsp_zero_denominator_error)
);
